/* hdl/prf_pkg.sv */
// shared types, constants and helpers for the partial register file
package prf_pkg;

   // store geometry
   localparam int NUM_SLOTS = 36;
   localparam int NUM_GPRS  = 16;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int DATA_W    = 64;

   // slot field compares are done one bit wider so the limits may reach 64
   localparam logic [6:0] SLOT_LIMIT = 7'(NUM_SLOTS);
   localparam logic [6:0] GPR_LIMIT  = 7'(NUM_GPRS);
   localparam logic [5:0] IP_SLOT    = 6'd16;
   localparam logic [5:0] HIGH_LIMIT = 6'd4;

   // access kind
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   // access width codes
   localparam logic [1:0] SIZE_BYTE  = 2'd0;
   localparam logic [1:0] SIZE_WORD  = 2'd1;
   localparam logic [1:0] SIZE_DWORD = 2'd2;
   localparam logic [1:0] SIZE_QWORD = 2'd3;

   // request payload as held in the input register
   typedef struct packed {
      logic              mode;
      logic [5:0]        reg_slot;
      logic [1:0]        size_code;
      logic              high_byte;
      logic [DATA_W-1:0] write_value;
      logic [DATA_W-1:0] decoded_ip;
      logic [3:0]        decoded_length;
   } req_item_type;

   // write port of the slot store
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } ram_wr_type;

   // byte lanes selected by an access width
   function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] size_code);
      logic [DATA_W-1:0] m;
      case (size_code)
         SIZE_BYTE:  m = 64'h0000_0000_0000_00FF;
         SIZE_WORD:  m = 64'h0000_0000_0000_FFFF;
         SIZE_DWORD: m = 64'h0000_0000_FFFF_FFFF;
         SIZE_QWORD: m = 64'hFFFF_FFFF_FFFF_FFFF;
         default:    m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

/* hdl/x86_partial_register_file.sv */
// top level of the x86-64 partial register file
//
// Request channel req_*: one access per transfer, read or write of a 64-bit
// slot at 1, 2, 4 or 8 bytes, optionally the high byte of slots 0 to 3.
// Response channel rsp_*: exactly one transfer per request, in order, with
// the extracted value on a read or the new full slot value on a write.
// A read of the instruction pointer slot returns decoded_ip + decoded_length.
// A request passes the input register and then the response register.
// Throughput: one access per cycle while responses are taken; the slot
// store reads at acceptance and writes back as the item leaves the input
// register, so back-to-back accesses to one slot see each other's writes.
// Reset clears all control state and the per-slot valid bits, so every slot
// reads as zero at once; no clearing pass is needed.
// When the receiver stalls, the response holds in its register, the input
// register still takes one more request, and req_tready then drops until
// the response is taken.
module x86_partial_register_file import prf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // reg_slot[5:0], size_code[7:6], high_byte[8], write_value[72:9],
   // decoded_ip[136:73], decoded_length[140:137], zero pad [143:141]
   input  logic [143:0]  req_tdata,
   // mode[0]
   input  logic          req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // read_data[63:0]
   output logic [63:0]   rsp_tdata
);

   req_item_type      req_item;
   req_item_type      item_ff;
   logic              s1_vld_ff;
   logic              s1_vld_in;
   logic              rsp_vld_ff;
   logic              rsp_vld_in;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [DATA_W-1:0] slot_q;
   logic [DATA_W-1:0] result;
   ram_wr_type        wr;
   ram_wr_type        wr_gated;
   logic              req_xfer;
   logic              out_free;
   logic              s1_adv;

   // unpack the request
   always_comb begin
      req_item.mode           = req_tuser;
      req_item.reg_slot       = req_tdata[5:0];
      req_item.size_code      = req_tdata[7:6];
      req_item.high_byte      = req_tdata[8];
      req_item.write_value    = req_tdata[72:9];
      req_item.decoded_ip     = req_tdata[136:73];
      req_item.decoded_length = req_tdata[140:137];
   end

   // flow control
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign s1_adv     = s1_vld_ff && out_free;
   assign req_tready = !s1_vld_ff || s1_adv;
   assign req_xfer   = req_tvalid && req_tready;
   assign s1_vld_in  = req_xfer || (s1_vld_ff && !s1_adv);
   assign rsp_vld_in = s1_adv || (rsp_vld_ff && !rsp_tready);

   // write back only as the item moves to the response register
   always_comb begin
      wr_gated    = wr;
      wr_gated.en = wr.en && s1_adv;
   end

   prf_slot_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr_gated),
      .rd_en   (req_xfer),
      .rd_addr (req_item.reg_slot[SLOT_W-1:0]),
      .rd_data (slot_q)
   );

   prf_merge u_merge (
      .item   (item_ff),
      .slot_q (slot_q),
      .result (result),
      .wr     (wr)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff <= req_item;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // a response appears only from an occupied input register
   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(s1_vld_ff))
      else $error("response raised with empty input register");

   // the store is written only as an item leaves the input register
   a_wr_on_adv: assert property (@(posedge clock) disable iff (reset)
      wr_gated.en |-> (s1_vld_ff && out_free))
      else $error("store written without an advancing item");

   // no write reaches a slot beyond the store
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_gated.en |-> ({1'b0, wr_gated.addr} < SLOT_LIMIT[SLOT_W:0]))
      else $error("write to a slot outside the store");

   // back-pressure only when both registers are full and the output is stalled
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_vld_ff && rsp_vld_ff && !rsp_tready))
      else $error("request refused with room available");
`endif

endmodule

/* hdl/prf_slot_ram.sv */
// slot store: one write and one registered read per cycle, write-first, per-entry valid bits
module prf_slot_ram import prf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ram_wr_type        wr,
   input  logic              rd_en,
   input  logic [SLOT_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic rd_ok;
   logic wr_ok;

   assign rd_ok = ({1'b0, rd_addr} < SLOT_LIMIT[SLOT_W:0]);
   assign wr_ok = wr.en && ({1'b0, wr.addr} < SLOT_LIMIT[SLOT_W:0]);

   // entry array, no reset; validity tracked separately
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_ok) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // registered read, a same-cycle write to the same entry passes straight through
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_ok && (wr.addr == rd_addr)) begin
            rd_data_ff <= wr.data;
         end else if (rd_ok && valid_ff[rd_addr]) begin
            rd_data_ff <= mem[rd_addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/prf_merge.sv */
// access logic: extracts on read (IP slot: decoded_ip + decoded_length), merges or zero-extends on write
module prf_merge import prf_pkg::*; (
   input  req_item_type      item,
   input  logic [DATA_W-1:0] slot_q,
   output logic [DATA_W-1:0] result,
   output ram_wr_type        wr
);

   logic              high;
   logic              in_range;
   logic              is_gpr;
   logic [DATA_W-1:0] wmask;
   logic [DATA_W-1:0] amask;
   logic [DATA_W-1:0] ins;
   logic [DATA_W-1:0] merged;
   logic [DATA_W-1:0] extract;
   logic [DATA_W-1:0] ip_sum;

   // decode of the slot and width
   always_comb begin
      high     = item.high_byte && (item.size_code == SIZE_BYTE) &&
                 (item.reg_slot < HIGH_LIMIT);
      in_range = ({1'b0, item.reg_slot} < SLOT_LIMIT);
      is_gpr   = ({1'b0, item.reg_slot} < GPR_LIMIT);
      wmask    = width_mask(item.size_code);
      amask    = high ? {wmask[DATA_W-9:0], 8'h00} : wmask;
   end

   // read extraction and write merge
   always_comb begin
      ins     = high ? {item.write_value[DATA_W-9:0], 8'h00} : item.write_value;
      ins     = ins & amask;
      merged  = (slot_q & ~amask) | ins;
      extract = slot_q & amask;
      extract = high ? {8'h00, extract[DATA_W-1:8]} : extract;
      ip_sum  = item.decoded_ip + DATA_W'(item.decoded_length);
   end

   // result and write-back
   always_comb begin
      result  = '0;
      wr.en   = 1'b0;
      wr.addr = item.reg_slot[SLOT_W-1:0];
      wr.data = merged;
      if (item.mode == MODE_WRITE) begin
         if ((item.size_code == SIZE_DWORD) && is_gpr) begin
            wr.data = {32'h0000_0000, item.write_value[31:0]};
         end
         wr.en = in_range;
         if (in_range) begin
            result = wr.data;
         end
      end else if (in_range) begin
         result = (item.reg_slot == IP_SLOT) ? ip_sum : extract;
      end
   end

endmodule

/* dv/prf_access_monitor.sv */
// channel monitor with register shadow and response comparison for the partial register file
module prf_access_monitor import prf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // reg_slot[5:0], size_code[7:6], high_byte[8], write_value[72:9],
   // decoded_ip[136:73], decoded_length[140:137], zero pad [143:141]
   input  logic [143:0] req_tdata,
   // mode[0]
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // read_data[63:0]
   input  logic [63:0]  rsp_tdata,
   output int           outstanding,
   output int           fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [DATA_W-1:0] slot_shadow [NUM_SLOTS];
   logic [DATA_W-1:0] expected_read_data [$];

   // apply one access to the shadow store and return the value it reads back
   function automatic logic [DATA_W-1:0] apply_access(input req_item_type a);
      logic              upper;
      int                shift;
      logic [DATA_W-1:0] lane;
      logic [DATA_W-1:0] field;
      logic [DATA_W-1:0] merged;
      upper = a.high_byte && (a.size_code == SIZE_BYTE) && (a.reg_slot < HIGH_LIMIT);
      shift = upper ? 8 : 0;
      lane  = (a.size_code == SIZE_QWORD) ? '1 : ((64'd1 << (8 << a.size_code)) - 64'd1);
      field = lane << shift;
      if (int'(a.reg_slot) >= NUM_SLOTS)
         return '0;
      if (a.mode == MODE_READ) begin
         // instruction pointer reads decoded_ip plus decoded_length, full width, store untouched
         if (a.reg_slot == IP_SLOT)
            return a.decoded_ip + 64'(a.decoded_length);
         return (slot_shadow[a.reg_slot] & field) >> shift;
      end
      // dword writes to general registers clear the upper half
      if (a.size_code == SIZE_DWORD && int'(a.reg_slot) < NUM_GPRS)
         merged = {32'd0, a.write_value[31:0]};
      else
         merged = (slot_shadow[a.reg_slot] & ~field) | ((a.write_value & lane) << shift);
      slot_shadow[a.reg_slot] = merged;
      return merged;
   endfunction

   initial fail_count = 0;

   // compare responses first, then predict the new request of the same edge
   always @(posedge clock) begin
      req_item_type a;
      logic [DATA_W-1:0] want;
      if (reset) begin
         foreach (slot_shadow[i]) slot_shadow[i] = '0;
         expected_read_data.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_read_data.size() == 0) begin
               $error("read_data: unexpected transfer, got %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_read_data.pop_front();
               if (rsp_tdata !== want) begin
                  $error("read_data: expected %h, got %h", want, rsp_tdata);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            a.mode           = req_tuser;
            a.reg_slot       = req_tdata[5:0];
            a.size_code      = req_tdata[7:6];
            a.high_byte      = req_tdata[8];
            a.write_value    = req_tdata[72:9];
            a.decoded_ip     = req_tdata[136:73];
            a.decoded_length = req_tdata[140:137];
            expected_read_data.push_back(apply_access(a));
         end
      end
      outstanding <= expected_read_data.size();
   end

endmodule

/* dv/tb_x86_partial_register_file.sv */
// top-level testbench for the partial register file: stimulus, back-pressure and verdict
module tb_x86_partial_register_file;
   import prf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 80;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata  = '0;
   logic         req_tuser  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;

   int outstanding;
   int fail_count;
   int cycle_count = 0;
   bit steady      = 1'b0;

   always #1 clock = ~clock;

   x86_partial_register_file u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   prf_access_monitor u_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   // offer one access, with random gaps, until it is transferred
   task automatic access(input logic mode, input logic [5:0] slot, input logic [1:0] size,
                         input logic hb, input logic [63:0] wval, input logic [63:0] dip,
                         input logic [3:0] dlen);
      while (!steady && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {3'b000, dlen, dip, wval, hb, size, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // receiver: random stalls, one long hold-off, a calm stretch
   always @(posedge clock) begin
      static int rsp_seen  = 0;
      static int hold_left = 0;
      static bit hold_done = 1'b0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) rsp_seen++;
         if (!hold_done && rsp_seen >= 250) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 12);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      logic        mode;
      logic [5:0]  slot;
      logic [1:0]  size;
      logic [63:0] wval;
      logic [63:0] dip;
      int          pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // full write then every read width, low and high byte
      access(MODE_WRITE, 6'd0, SIZE_QWORD, 1'b0, 64'h8877_6655_4433_2211, '0, 4'd0);
      access(MODE_READ,  6'd0, SIZE_BYTE,  1'b0, '0, '0, 4'd0);
      access(MODE_READ,  6'd0, SIZE_BYTE,  1'b1, '0, '0, 4'd0);
      access(MODE_READ,  6'd0, SIZE_WORD,  1'b0, '0, '0, 4'd0);
      access(MODE_READ,  6'd0, SIZE_DWORD, 1'b0, '0, '0, 4'd0);
      access(MODE_READ,  6'd0, SIZE_QWORD, 1'b0, '0, '0, 4'd0);
      // high byte write merges into bits 15:8; the flag is ignored on a word write
      access(MODE_WRITE, 6'd3, SIZE_BYTE,  1'b1, '1, '0, 4'd0);
      access(MODE_WRITE, 6'd3, SIZE_WORD,  1'b1, 64'h0000_0000_0000_1234, '0, 4'd0);
      // high byte ignored outside slots 0 to 3
      access(MODE_WRITE, 6'd4, SIZE_BYTE,  1'b1, 64'h0000_0000_0000_00A5, '0, 4'd0);
      access(MODE_READ,  6'd4, SIZE_BYTE,  1'b1, '0, '0, 4'd0);
      // dword zero-extends on a general register, merges elsewhere
      access(MODE_WRITE, 6'd15, SIZE_QWORD, 1'b0, '1, '0, 4'd0);
      access(MODE_WRITE, 6'd15, SIZE_DWORD, 1'b0, 64'hFFFF_FFFF_0000_0001, '0, 4'd0);
      access(MODE_WRITE, 6'd20, SIZE_QWORD, 1'b0, '1, '0, 4'd0);
      access(MODE_WRITE, 6'd20, SIZE_DWORD, 1'b0, '0, '0, 4'd0);
      // IP reads: wrapping sum, unmasked, store not consulted; IP writes hit the store
      access(MODE_READ,  IP_SLOT, SIZE_BYTE,  1'b0, '0, '1, 4'd15);
      access(MODE_WRITE, IP_SLOT, SIZE_WORD,  1'b1, '1, '0, 4'd0);
      access(MODE_READ,  IP_SLOT, SIZE_QWORD, 1'b0, '0, 64'h0000_7FFF_FFFF_FFF0, 4'd0);
      access(MODE_WRITE, IP_SLOT, SIZE_QWORD, 1'b0, 64'h1234_5678_9ABC_DEF0, '0, 4'd0);
      // last slot and out-of-range slots
      access(MODE_WRITE, 6'(NUM_SLOTS - 1), SIZE_QWORD, 1'b0, '1, '0, 4'd0);
      access(MODE_READ,  6'(NUM_SLOTS - 1), SIZE_WORD,  1'b0, '0, '0, 4'd0);
      access(MODE_WRITE, 6'(NUM_SLOTS), SIZE_QWORD, 1'b0, '1, '1, 4'd15);
      access(MODE_READ,  6'(NUM_SLOTS), SIZE_QWORD, 1'b0, '0, '1, 4'd15);
      access(MODE_READ,  6'd63, SIZE_BYTE, 1'b1, '1, '1, 4'd15);

      // random accesses, mostly in range, biased to slots 0 to 3 and IP
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 500 && n < 700);
         pick = $urandom_range(99);
         if (pick < 30)      slot = 6'($urandom_range(3));
         else if (pick < 40) slot = IP_SLOT;
         else if (pick < 92) slot = 6'($urandom_range(NUM_SLOTS - 1));
         else                slot = 6'($urandom_range(63, NUM_SLOTS));
         mode = 1'($urandom_range(1));
         size = 2'($urandom_range(3));
         pick = $urandom_range(9);
         wval = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
         dip  = ($urandom_range(9) == 0) ? '1 : {$urandom, $urandom};
         access(mode, slot, size, 1'($urandom_range(1)), wval, dip, 4'($urandom_range(15)));
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      // drain, then allow for the pipeline latency
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* files.f */
hdl/prf_pkg.sv
hdl/prf_slot_ram.sv
hdl/prf_merge.sv
hdl/x86_partial_register_file.sv
dv/prf_access_monitor.sv
dv/tb_x86_partial_register_file.sv
